>>> src/mmdd_pkg.sv
// shared constants, types and helper functions for the descriptor decode core
// no dependencies; imported by memory_map_descriptor_decode_core
`default_nettype none

package mmdd_pkg;

	localparam int unsigned ADDR_W       = 32;
	localparam int unsigned LEN_W        = 33;
	localparam int unsigned IDX_W        = 4;
	localparam int unsigned ACT_W        = 5;
	localparam int unsigned CNT_W        = 5;
	localparam int unsigned DEF_ENTRIES  = 16;
	// slots reachable by the 4-bit write index
	localparam int unsigned SLOTS        = 1 << IDX_W;

	localparam int unsigned IN_BITS      = ADDR_W + IDX_W + ADDR_W + LEN_W + ADDR_W + ADDR_W;
	localparam int unsigned IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS     = 1 + IDX_W + ADDR_W;
	localparam int unsigned OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

	localparam logic ACTION_WRITE  = 1'b0;
	localparam logic ACTION_LOOKUP = 1'b1;

	// bit compaction state: present bits, data bits, remaining shift per position
	typedef struct packed {
		logic [ADDR_W-1:0]            e;
		logic [ADDR_W-1:0]            d;
		logic [ADDR_W-1:0][CNT_W-1:0] c;
	} cmp_t;

	// per lane state from match check to final compare
	typedef struct packed {
		logic             pre_ok;
		logic [LEN_W-1:0] len;
		cmp_t             cmp;
	} lane_t;

	// one compaction step: elements whose shift count has bit k set move down by 2^k
	function automatic cmp_t cmp_step(input cmp_t x, input int k);
		cmp_t y;
		int   s;
		s = 1 << k;
		for (int p = 0; p < ADDR_W; p++) begin
			y.e[p] = x.e[p] & ~x.c[p][k];
			y.d[p] = x.d[p] & x.e[p] & ~x.c[p][k];
			y.c[p] = (x.e[p] & ~x.c[p][k]) ? x.c[p] : '0;
			if (p + s < ADDR_W) begin
				if (x.e[p+s] && x.c[p+s][k]) begin
					y.e[p] = 1'b1;
					y.d[p] = x.d[p+s];
					y.c[p] = x.c[p+s];
				end
			end
		end
		return y;
	endfunction

	// per position count of masked bits below it
	function automatic logic [ADDR_W-1:0][CNT_W-1:0] prefix_counts(input logic [ADDR_W-1:0] m);
		logic [ADDR_W-1:0][CNT_W-1:0] r;
		logic [ADDR_W-1:0]            below;
		for (int p = 0; p < ADDR_W; p++) begin
			below = m & ((ADDR_W'(1) << p) - ADDR_W'(1));
			r[p]  = CNT_W'($countones(below));
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/memory_map_descriptor_decode_core.sv
// memory map descriptor decode core: descriptor table and pipelined first-match lookup
// depends on mmdd_pkg
`default_nettype none

// usage
//   slave stream carries items: tuser is the action (0 writes a descriptor,
//   1 looks up an address), tdata holds address and the descriptor fields.
//   every item yields exactly one transfer on the master stream: hit, index
//   of the first matching descriptor and the offset inside it (all zero on a
//   write item or a miss).
//   cfg_we / cfg_wdata set the number of scanned descriptors; write it only
//   while the block is idle.
// timing
//   one item per cycle sustained while m_tready stays high; an accepted item
//   reaches the output register through five register stages behind the
//   input register: match check, two compaction stages, priority pick, mux.
//   the descriptor table is written when a write item leaves the first
//   stage, so a lookup right behind it already sees the new entry.
// reset
//   arst_n clears all valid bits and the scan count; table contents stay
//   undefined until written.
// stalls
//   each stage holds while the next is full and blocked, so bubbles are
//   squeezed out and new items are taken while a result waits on m_tready.

module memory_map_descriptor_decode_core #(
	parameter int unsigned NUM_ENTRIES = mmdd_pkg::DEF_ENTRIES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [mmdd_pkg::ACT_W-1:0]      cfg_wdata,   // active_entries
	// input items
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// address[31:0], entry_index[35:32], entry_start[67:36], entry_length[100:68],
	// entry_select[132:101], entry_disconnect[164:133], zero fill
	input  wire logic [mmdd_pkg::IN_DATA_W-1:0]  s_tdata,
	input  wire logic [0:0]                      s_tuser,     // action
	// result items
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// hit[0], entry_found[4:1], local_offset[36:5], zero fill
	output logic [mmdd_pkg::OUT_DATA_W-1:0]      m_tdata
);

	import mmdd_pkg::*;

	// slots beyond the write index range can never be loaded
	localparam int unsigned LANES = (NUM_ENTRIES < SLOTS) ? NUM_ENTRIES : SLOTS;

	// configuration register
	logic [ACT_W-1:0] active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (cfg_we) begin
			active_q <= cfg_wdata;
		end
	end

	// stage enables: a stage loads when empty or when its content moves on
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5, en_out;

	assign en_out   = !m_tvalid || m_tready;
	assign en5      = !v_s5 || en_out;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en1)    v_s1     <= s_tvalid;
			if (en2)    v_s2     <= v_s1;
			if (en3)    v_s3     <= v_s2;
			if (en4)    v_s4     <= v_s3;
			if (en5)    v_s5     <= v_s4;
			if (en_out) m_tvalid <= v_s5;
		end
	end

	// stage 1: input register
	logic              action_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [ADDR_W-1:0] start_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [ADDR_W-1:0] sel_s1;
	logic [ADDR_W-1:0] disc_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			action_s1 <= s_tuser[0];
			addr_s1   <= s_tdata[31:0];
			idx_s1    <= s_tdata[35:32];
			start_s1  <= s_tdata[67:36];
			len_s1    <= s_tdata[100:68];
			sel_s1    <= s_tdata[132:101];
			disc_s1   <= s_tdata[164:133];
		end
	end

	// descriptor table, one row per lane, each read only by its own lane
	logic [ADDR_W-1:0]            start_q [LANES];
	logic [LEN_W-1:0]             len_q   [LANES];
	logic [ADDR_W-1:0]            sel_q   [LANES];
	logic [ADDR_W-1:0]            disc_q  [LANES];
	logic [ADDR_W-1:0][CNT_W-1:0] cnt_q   [LANES];

	logic                         wr_go;
	logic [ADDR_W-1:0][CNT_W-1:0] wr_cnt;

	// commit a write as it leaves stage 1
	assign wr_go  = v_s1 && en2 && (action_s1 == ACTION_WRITE);
	assign wr_cnt = prefix_counts(disc_s1);

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (wr_go && (idx_s1 == IDX_W'(l))) begin
				start_q[l] <= start_s1;
				len_q[l]   <= len_s1;
				sel_q[l]   <= sel_s1;
				disc_q[l]  <= disc_s1;
				cnt_q[l]   <= wr_cnt;
			end
		end
	end

	// stage 1 logic: difference, range or select check per lane
	lane_t lane_d1 [LANES];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			logic [ADDR_W-1:0] diff;
			logic              range_mode;
			logic              ok;
			diff       = addr_s1 - start_q[l];
			range_mode = (sel_q[l] == '0);
			ok         = range_mode ? (addr_s1 >= start_q[l])
			                        : (((start_q[l] ^ addr_s1) & sel_q[l]) == '0);
			lane_d1[l].pre_ok = ok && (action_s1 == ACTION_LOOKUP) &&
			                    (ACT_W'(l) < active_q);
			lane_d1[l].len    = len_q[l];
			// range mode: no bits removed, compaction passes diff through
			lane_d1[l].cmp.e  = range_mode ? '1 : ~disc_q[l];
			lane_d1[l].cmp.d  = range_mode ? diff : (diff & ~disc_q[l]);
			lane_d1[l].cmp.c  = range_mode ? '0 : cnt_q[l];
		end
	end

	// stage 2: compaction steps by 1, 2, 4
	lane_t lane_s2 [LANES];
	lane_t lane_d2 [LANES];

	always_ff @(posedge clk) begin
		if (en2) lane_s2 <= lane_d1;
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_d2[l]     = lane_s2[l];
			lane_d2[l].cmp = cmp_step(cmp_step(cmp_step(lane_s2[l].cmp, 0), 1), 2);
		end
	end

	// stage 3: compaction steps by 8, 16, then offset below length
	lane_t             lane_s3 [LANES];
	logic [LANES-1:0]  hit_d3;
	logic [ADDR_W-1:0] off_d3  [LANES];

	always_ff @(posedge clk) begin
		if (en3) lane_s3 <= lane_d2;
	end

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			cmp_t fin;
			fin       = cmp_step(cmp_step(lane_s3[l].cmp, 3), 4);
			off_d3[l] = fin.d;
			hit_d3[l] = lane_s3[l].pre_ok && ({1'b0, fin.d} < lane_s3[l].len);
		end
	end

	// stage 4: first matching lane
	logic [LANES-1:0]  hit_s4;
	logic [ADDR_W-1:0] off_s4 [LANES];
	logic              any_d4;
	logic [IDX_W-1:0]  idx_d4;

	always_ff @(posedge clk) begin
		if (en4) begin
			hit_s4 <= hit_d3;
			off_s4 <= off_d3;
		end
	end

	always_comb begin
		any_d4 = |hit_s4;
		idx_d4 = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (hit_s4[l]) idx_d4 = IDX_W'(l);
		end
	end

	// stage 5: offset select
	logic              any_s5;
	logic [IDX_W-1:0]  idx_s5;
	logic [ADDR_W-1:0] off_s5 [LANES];
	logic [ADDR_W-1:0] off_d5;

	always_ff @(posedge clk) begin
		if (en5) begin
			any_s5 <= any_d4;
			idx_s5 <= idx_d4;
			off_s5 <= off_s4;
		end
	end

	always_comb begin
		off_d5 = '0;
		for (int l = 0; l < LANES; l++) begin
			if (any_s5 && (idx_s5 == IDX_W'(l))) off_d5 = off_s5[l];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en_out) begin
			m_tdata <= OUT_DATA_W'({off_d5, idx_s5, any_s5});
		end
	end

endmodule

`default_nettype wire
